[hw/rtl/pcm_pkg.sv]
package pcm_pkg;

	localparam int CompBits = 16;
	localparam int SqW      = 2 * CompBits;
	localparam int SumW     = 32;
	localparam int RootW    = SumW / 2;
	localparam int RemW     = RootW + 2;
	localparam int OutW     = 16;

	typedef struct packed {
		logic                valid;
		logic [SumW-1:0]     rad;
		logic [RemW-1:0]     rem;
		logic [RootW-1:0]    root;
	} cell_word_t;

	function automatic logic [CompBits-1:0] mag(input logic [CompBits-1:0] v);
		logic [CompBits-1:0] r;
		r = v[CompBits-1] ? (~v + CompBits'(1)) : v;
		return r;
	endfunction

endpackage

[hw/rtl/packed_complex_magnitude.sv]
// An accepted bin word becomes its magnitude word through the front stages and the root cells below.
// Throughput: one word per cycle unless the output stalls; three front stages (magnitude, square, sum)
// feed a row of 16 root cells, one result bit per cell.
// The whole row holds while a finished word waits at the output.
// Reset (arst_n low) empties every stage at once; no word is in flight after it.
module packed_complex_magnitude (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        bin_valid,
	output logic        bin_ready,
	input  logic [31:0] packed_bin,
	output logic        mag_valid,
	input  logic        mag_ready,
	output logic [15:0] doubled_magnitude
);

	pcm_pkg::cell_word_t chain [pcm_pkg::RootW+1];
	logic                en;

	assign en        = !chain[pcm_pkg::RootW].valid || mag_ready;
	assign bin_ready = en;

	pcm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.bin_valid  (bin_valid),
		.packed_bin (packed_bin),
		.cell_o     (chain[0])
	);

	for (genvar i = 0; i < pcm_pkg::RootW; i++) begin : g_cell
		pcm_root_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.cell_i (chain[i]),
			.cell_o (chain[i+1])
		);
	end

	assign mag_valid         = chain[pcm_pkg::RootW].valid;
	assign doubled_magnitude = {chain[pcm_pkg::RootW].root[pcm_pkg::OutW-2:0], 1'b0};

endmodule

[hw/rtl/pcm_front.sv]
module pcm_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          bin_valid,
	input  logic [31:0]                   packed_bin,
	output pcm_pkg::cell_word_t           cell_o
);

	logic                          valid_s1, valid_s2, valid_s3;
	logic [pcm_pkg::CompBits-1:0]  re_s1, im_s1;
	logic [pcm_pkg::SqW-1:0]       re_sq_s2, im_sq_s2;
	logic [pcm_pkg::SumW-1:0]      sum_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= bin_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			re_s1    <= pcm_pkg::mag(packed_bin[pcm_pkg::CompBits-1:0]);
			im_s1    <= pcm_pkg::mag(packed_bin[2*pcm_pkg::CompBits-1:pcm_pkg::CompBits]);
			re_sq_s2 <= pcm_pkg::SqW'(re_s1) * pcm_pkg::SqW'(re_s1);
			im_sq_s2 <= pcm_pkg::SqW'(im_s1) * pcm_pkg::SqW'(im_s1);
			sum_s3   <= pcm_pkg::SumW'(re_sq_s2 + im_sq_s2);
		end
	end

	always_comb begin
		cell_o.valid = valid_s3;
		cell_o.rad   = sum_s3;
		cell_o.rem   = '0;
		cell_o.root  = '0;
	end

endmodule

[hw/rtl/pcm_root_cell.sv]
module pcm_root_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  pcm_pkg::cell_word_t   cell_i,
	output pcm_pkg::cell_word_t   cell_o
);

	localparam int ExtW = pcm_pkg::RemW + 2;

	logic [pcm_pkg::RootW-1:0] root_sh;
	logic [ExtW-1:0]           rem_ext;
	logic [ExtW-1:0]           trial;
	logic [ExtW-1:0]           diff;
	logic                      take;
	pcm_pkg::cell_word_t       nxt;
	pcm_pkg::cell_word_t       cell_q;

	always_comb begin
		root_sh   = {cell_i.root[pcm_pkg::RootW-2:0], 1'b0};
		rem_ext   = {cell_i.rem, cell_i.rad[pcm_pkg::SumW-1 -: 2]};
		trial     = ExtW'({root_sh, 1'b1});
		diff      = rem_ext - trial;
		take      = (trial <= rem_ext);
		nxt.valid = cell_i.valid;
		nxt.rad   = {cell_i.rad[pcm_pkg::SumW-3:0], 2'b00};
		nxt.rem   = take ? diff[pcm_pkg::RemW-1:0] : rem_ext[pcm_pkg::RemW-1:0];
		nxt.root  = take ? (root_sh | pcm_pkg::RootW'(1)) : root_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q <= '0;
		end else if (en) begin
			cell_q <= nxt;
		end
	end

	assign cell_o = cell_q;

endmodule

[hw/rtl/pcm_checker.sv]
module pcm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        bin_valid,
	input logic        bin_ready,
	input logic [31:0] packed_bin,
	input logic        mag_valid,
	input logic        mag_ready,
	input logic [15:0] doubled_magnitude
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		mag_valid && !mag_ready |=> mag_valid && $stable(doubled_magnitude))
		else $error("output word dropped or changed while stalled");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		bin_ready == (!mag_valid || mag_ready))
		else $error("input ready does not follow output stall");

	a_even: assert property (@(posedge clk) disable iff (!arst_n)
		mag_valid |-> !doubled_magnitude[0])
		else $error("doubled magnitude is odd");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		bin_valid && !bin_ready |=> bin_valid && $stable(packed_bin))
		else $error("input word dropped or changed while stalled");

endmodule

bind packed_complex_magnitude pcm_checker u_pcm_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.bin_valid         (bin_valid),
	.bin_ready         (bin_ready),
	.packed_bin        (packed_bin),
	.mag_valid         (mag_valid),
	.mag_ready         (mag_ready),
	.doubled_magnitude (doubled_magnitude)
);
